>>> rtl/olis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list insert/search: shared package
// Sizes, operation and status codes, and the node store write command.
// ----------------------------------------------------------------------------
package olis_pkg;

   // Number of node slots in the store.
   localparam int Capacity = 64;

   // Width of a node index and of the node counter (which must hold Capacity).
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);

   // Field widths.
   localparam int ValW  = 32;
   localparam int PosW  = 8;
   localparam int SumW  = 38;
   localparam int StatW = 3;
   localparam int FidxW = 6;
   localparam int NcntW = 7;

   // Width used to compare a position against the node count.
   localparam int CmpW = (CntW > PosW) ? CntW : PosW;

   // Request operation codes.
   localparam logic [1:0] MODE_HEAD   = 2'd0;
   localparam logic [1:0] MODE_TAIL   = 2'd1;
   localparam logic [1:0] MODE_AFTER  = 2'd2;
   localparam logic [1:0] MODE_SEARCH = 2'd3;

   // Response status codes.
   localparam logic [StatW-1:0] ST_OK       = 3'd0;
   localparam logic [StatW-1:0] ST_BADPOS   = 3'd1;
   localparam logic [StatW-1:0] ST_EMPTY    = 3'd2;
   localparam logic [StatW-1:0] ST_FULL     = 3'd3;
   localparam logic [StatW-1:0] ST_NOTFOUND = 3'd4;

   // Write command to the node store: one value write and one link write.
   typedef struct packed {
      logic            val_we;
      logic [IdxW-1:0] val_addr;
      logic [ValW-1:0] val_data;
      logic            link_we;
      logic [IdxW-1:0] link_addr;
      logic [IdxW-1:0] link_data;
   } olis_wr_type;

endpackage

>>> rtl/olis_node_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list insert/search: node store
// Value memory and next-link memory, one shared read address, registered
// read data, one write port on each memory.
// ----------------------------------------------------------------------------
module olis_node_store (
   input  logic                             clock,
   input  logic [olis_pkg::IdxW-1:0]        rd_addr,
   input  olis_pkg::olis_wr_type            wr,
   output logic [olis_pkg::ValW-1:0]        value_rdata,
   output logic [olis_pkg::IdxW-1:0]        link_rdata
);
   import olis_pkg::*;

   logic [ValW-1:0] value_mem [Capacity];
   logic [IdxW-1:0] link_mem  [Capacity];

   // Value memory: write port and registered read.
   always_ff @(posedge clock) begin
      if (wr.val_we) begin
         value_mem[wr.val_addr] <= wr.val_data;
      end
      value_rdata <= value_mem[rd_addr];
   end

   // Link memory: write port and registered read.
   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[wr.link_addr] <= wr.link_data;
      end
      link_rdata <= link_mem[rd_addr];
   end

endmodule

>>> rtl/ordered_list_insert_search_core.sv
`timescale 1ns / 1ps
// A rejected request, or a search of an empty list, answers on the cycle after start
// without raising busy. Busy is held while a head or tail insert writes, while an insert
// after node k walks to node k and writes, and while a search runs until it ends at a
// match or the last node; the result strobe follows in the cycle busy falls, and a new
// request is taken then. The walk reads one node per cycle. Synchronous reset empties
// the list at once; the store is not cleared.
// ----------------------------------------------------------------------------
// Ordered list insert/search core
// Bounded singly linked list of signed values with head, tail and
// insert-after inserts, first-match search, node count and running sum.
// ----------------------------------------------------------------------------
module ordered_list_insert_search_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_mode,
   input  logic signed [olis_pkg::ValW-1:0]   req_value,
   input  logic signed [olis_pkg::PosW-1:0]   req_position,
   output logic                               rsp_valid,
   output logic [olis_pkg::StatW-1:0]         rsp_status,
   output logic [olis_pkg::FidxW-1:0]         rsp_found_index,
   output logic [olis_pkg::NcntW-1:0]         rsp_node_count,
   output logic signed [olis_pkg::SumW-1:0]   rsp_total_sum
);
   import olis_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SRCH,
      S_WR1,
      S_WR2
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   // List bookkeeping.
   logic [IdxW-1:0]        head_ff;
   logic [IdxW-1:0]        tail_ff;
   logic [CntW-1:0]        count_ff;
   logic signed [SumW-1:0] sum_ff;

   // Per-request working registers.
   logic [ValW-1:0]        value_ff;
   logic [IdxW-1:0]        cur_ff;
   logic [IdxW-1:0]        steps_ff;
   logic [IdxW-1:0]        idx_ff;
   logic [IdxW-1:0]        new_link_ff;
   logic [IdxW-1:0]        fix_addr_ff;
   logic                   second_wr_ff;
   logic                   set_head_ff;
   logic                   set_tail_ff;

   // Response registers.
   logic [StatW-1:0]       rsp_status_ff;
   logic [FidxW-1:0]       rsp_fidx_ff;
   logic [NcntW-1:0]       rsp_count_ff;
   logic signed [SumW-1:0] rsp_sum_ff;

   // Node store interface.
   logic [IdxW-1:0]        rd_addr;
   olis_wr_type            wr;
   logic [ValW-1:0]        value_rdata;
   logic [IdxW-1:0]        link_rdata;

   // Derived values.
   logic                   accept;
   logic                   full;
   logic [IdxW-1:0]        slot;
   logic [PosW-2:0]        target;
   logic [CntW-1:0]        count_plus;
   logic signed [SumW-1:0] sum_plus;
   logic                   more_nodes;

   olis_node_store u_store (
      .clock       (clock),
      .rd_addr     (rd_addr),
      .wr          (wr),
      .value_rdata (value_rdata),
      .link_rdata  (link_rdata)
   );

   assign accept     = start && !busy_ff;
   assign full       = (count_ff == CntW'(Capacity));
   assign slot       = count_ff[IdxW-1:0];
   assign count_plus = count_ff + CntW'(1);
   assign sum_plus   = sum_ff + {{(SumW-ValW){value_ff[ValW-1]}}, value_ff};
   assign more_nodes = (CntW'(idx_ff) + CntW'(1)) < count_ff;

   // Target node of an insert after: position minus one, but not below zero.
   assign target = (req_position[PosW-2:0] == '0) ? '0 : req_position[PosW-2:0] - 1'b1;

   // While idle the head is read so a walk or search can start at once;
   // during a walk or search the next address is the link just read.
   always_comb begin
      case (state_ff)
         S_WALK:  rd_addr = link_rdata;
         S_SRCH:  rd_addr = link_rdata;
         default: rd_addr = head_ff;
      endcase
   end

   // Store writes: the new node first, then the predecessor's link.
   always_comb begin
      wr           = '0;
      wr.val_addr  = slot;
      wr.val_data  = value_ff;
      wr.link_addr = slot;
      wr.link_data = new_link_ff;
      case (state_ff)
         S_WR1: begin
            wr.val_we  = 1'b1;
            wr.link_we = 1'b1;
         end
         S_WR2: begin
            wr.link_we   = 1'b1;
            wr.link_addr = fix_addr_ff;
            wr.link_data = slot;
         end
         default: begin
            wr.val_we  = 1'b0;
            wr.link_we = 1'b0;
         end
      endcase
   end

   // Sequencer, list bookkeeping and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  value_ff      <= req_value;
                  cur_ff        <= head_ff;
                  idx_ff        <= '0;
                  fix_addr_ff   <= tail_ff;
                  rsp_fidx_ff   <= '0;
                  rsp_count_ff  <= NcntW'(count_ff);
                  rsp_sum_ff    <= sum_ff;
                  case (req_mode)
                     MODE_HEAD, MODE_TAIL: begin
                        if (full) begin
                           rsp_status_ff <= ST_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           new_link_ff  <= (count_ff == '0 || req_mode == MODE_TAIL) ?
                                           '0 : head_ff;
                           second_wr_ff <= (req_mode == MODE_TAIL) && (count_ff != '0);
                           set_head_ff  <= (req_mode == MODE_HEAD) || (count_ff == '0);
                           set_tail_ff  <= (req_mode == MODE_TAIL) || (count_ff == '0);
                           busy_ff      <= 1'b1;
                           state_ff     <= S_WR1;
                        end
                     end
                     MODE_AFTER: begin
                        if (req_position[PosW-1]) begin
                           rsp_status_ff <= ST_BADPOS;
                           rsp_valid_ff  <= 1'b1;
                        end else if (count_ff == '0) begin
                           rsp_status_ff <= ST_EMPTY;
                           rsp_valid_ff  <= 1'b1;
                        end else if (CmpW'(target) >= CmpW'(count_ff)) begin
                           rsp_status_ff <= ST_BADPOS;
                           rsp_valid_ff  <= 1'b1;
                        end else if (full) begin
                           rsp_status_ff <= ST_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           steps_ff     <= IdxW'(target);
                           second_wr_ff <= 1'b1;
                           set_head_ff  <= 1'b0;
                           busy_ff      <= 1'b1;
                           state_ff     <= S_WALK;
                        end
                     end
                     default: begin
                        if (count_ff == '0) begin
                           rsp_status_ff <= ST_NOTFOUND;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           busy_ff  <= 1'b1;
                           state_ff <= S_SRCH;
                        end
                     end
                  endcase
               end
            end

            // Follow links until the target node; its link is then on hand.
            S_WALK: begin
               if (steps_ff == '0) begin
                  fix_addr_ff <= cur_ff;
                  set_tail_ff <= (cur_ff == tail_ff);
                  new_link_ff <= (cur_ff == tail_ff) ? '0 : link_rdata;
                  state_ff    <= S_WR1;
               end else begin
                  cur_ff   <= link_rdata;
                  steps_ff <= steps_ff - 1'b1;
               end
            end

            // Compare one node per cycle, following links in order.
            S_SRCH: begin
               if (value_rdata == value_ff) begin
                  rsp_status_ff <= ST_OK;
                  rsp_fidx_ff   <= FidxW'(idx_ff);
                  rsp_valid_ff  <= 1'b1;
                  busy_ff       <= 1'b0;
                  state_ff      <= S_IDLE;
               end else if (more_nodes) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  rsp_status_ff <= ST_NOTFOUND;
                  rsp_valid_ff  <= 1'b1;
                  busy_ff       <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end

            S_WR1, S_WR2: begin
               if (state_ff == S_WR1 && second_wr_ff) begin
                  state_ff <= S_WR2;
               end else begin
                  // Commit the insert and report it.
                  count_ff      <= count_plus;
                  sum_ff        <= sum_plus;
                  if (set_head_ff) begin
                     head_ff <= slot;
                  end
                  if (set_tail_ff) begin
                     tail_ff <= slot;
                  end
                  rsp_status_ff <= ST_OK;
                  rsp_count_ff  <= NcntW'(count_plus);
                  rsp_sum_ff    <= sum_plus;
                  rsp_valid_ff  <= 1'b1;
                  busy_ff       <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_node_count  = rsp_count_ff;
   assign rsp_total_sum   = rsp_sum_ff;

   // A response never appears while a request is still in progress.
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid_ff && busy_ff))
      else $error("response strobe while busy");

   // An accepted request either starts work or answers on the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> (busy_ff || rsp_valid_ff))
      else $error("accepted request neither started nor answered");

   // The node count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(Capacity))
      else $error("node count above capacity");

   // The count only grows by one, and only with a response.
   assert property (@(posedge clock) disable iff (reset)
                    (!$past(reset) && !$stable(count_ff)) |->
                    (rsp_valid_ff && count_ff == $past(count_ff) + CntW'(1)))
      else $error("node count changed unexpectedly");

endmodule

>>> dv/olis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list insert/search: result checker
// Watches the request and response ports of the list core. It keeps its own
// model of the linked list to work out the expected response for every
// accepted request, and compares each response strobe field by field with
// the oldest expected response. It reports the failure count and the number
// of responses still outstanding.
// ----------------------------------------------------------------------------
module olis_checker
   import olis_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [1:0]               req_mode,
   input  logic signed [ValW-1:0]   req_value,
   input  logic signed [PosW-1:0]   req_position,
   input  logic                     rsp_valid,
   input  logic [StatW-1:0]         rsp_status,
   input  logic [FidxW-1:0]         rsp_found_index,
   input  logic [NcntW-1:0]         rsp_node_count,
   input  logic signed [SumW-1:0]   rsp_total_sum,
   output int                       fail_count,
   output int                       pending
);

   // One response as the list core should give it.
   typedef struct packed {
      logic [StatW-1:0]       status;
      logic [FidxW-1:0]       fidx;
      logic [NcntW-1:0]       ncnt;
      logic signed [SumW-1:0] sum;
   } list_reply_type;

   // Model of the node store and the list registers.
   logic signed [ValW-1:0] node_val [Capacity];
   logic [IdxW-1:0]        node_nxt [Capacity];
   logic [IdxW-1:0]        head_idx = '0;
   logic [IdxW-1:0]        tail_idx = '0;
   int unsigned            node_cnt = 0;
   logic signed [SumW-1:0] list_sum = '0;

   // Responses owed by the core, oldest first.
   list_reply_type replies_due[$];
   list_reply_type due;
   int             mismatches = 0;

   // Store a new node in the next free slot and add its value to the sum.
   function automatic void store_node(input logic signed [ValW-1:0] value);
      logic [IdxW-1:0] slot;
      slot           = IdxW'(node_cnt);
      node_val[slot] = value;
      node_nxt[slot] = '0;
      node_cnt       = node_cnt + 1;
      list_sum       = list_sum + {{(SumW-ValW){value[ValW-1]}}, value};
   endfunction

   // Apply one request to the list model and return the response it earns.
   function automatic list_reply_type apply_request(input logic [1:0] mode,
                                                    input logic signed [ValW-1:0] value,
                                                    input logic signed [PosW-1:0] position);
      list_reply_type  r;
      logic [IdxW-1:0] slot;
      logic [IdxW-1:0] at;
      int unsigned     target;
      int unsigned     i;
      logic            hit;
      r.status = ST_OK;
      r.fidx   = '0;
      slot     = IdxW'(node_cnt);
      hit      = 1'b0;
      case (mode)
         MODE_HEAD, MODE_TAIL: begin
            if (node_cnt >= Capacity) begin
               r.status = ST_FULL;
            end else begin
               store_node(value);
               if (node_cnt == 1) begin
                  head_idx = slot;
                  tail_idx = slot;
               end else if (mode == MODE_HEAD) begin
                  node_nxt[slot] = head_idx;
                  head_idx       = slot;
               end else begin
                  node_nxt[tail_idx] = slot;
                  tail_idx           = slot;
               end
            end
         end
         MODE_AFTER: begin
            // Checks run in a fixed order: sign, empty list, range, full list.
            if (position < 0) begin
               r.status = ST_BADPOS;
            end else if (node_cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               target = (position == 0) ? 0 : int'(position) - 1;
               if (target >= node_cnt) begin
                  r.status = ST_BADPOS;
               end else if (node_cnt >= Capacity) begin
                  r.status = ST_FULL;
               end else begin
                  at = head_idx;
                  repeat (target) at = node_nxt[at];
                  store_node(value);
                  // Linking after the last node moves the tail.
                  if (at == tail_idx) begin
                     tail_idx = slot;
                  end else begin
                     node_nxt[slot] = node_nxt[at];
                  end
                  node_nxt[at] = slot;
               end
            end
         end
         default: begin
            // Search from the head for the first equal value.
            at = head_idx;
            for (i = 0; i < node_cnt && !hit; i++) begin
               if (node_val[at] == value) begin
                  hit    = 1'b1;
                  r.fidx = FidxW'(i);
               end else begin
                  at = node_nxt[at];
               end
            end
            if (!hit) begin
               r.status = ST_NOTFOUND;
            end
         end
      endcase
      r.ncnt = NcntW'(node_cnt);
      r.sum  = list_sum;
      return r;
   endfunction

   // Compare responses with the model and record every accepted request.
   always @(posedge clock) begin
      if (reset) begin
         head_idx = '0;
         tail_idx = '0;
         node_cnt = 0;
         list_sum = '0;
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] response with none outstanding: status %0d index %0d",
                           $realtime, rsp_status, rsp_found_index);
                  $display("   count %0d sum %0d", rsp_node_count, rsp_total_sum);
               end
            end else begin
               due = replies_due.pop_front();
               if (rsp_status != due.status || rsp_found_index != due.fidx ||
                   rsp_node_count != due.ncnt || rsp_total_sum != due.sum) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] response differs: status %0d/%0d index %0d/%0d",
                              $realtime, due.status, rsp_status, due.fidx, rsp_found_index);
                     $display("   count %0d/%0d sum %0d/%0d (expected/actual)",
                              due.ncnt, rsp_node_count, due.sum, rsp_total_sum);
                  end
               end
            end
         end
         if (start && !busy) begin
            replies_due.push_back(apply_request(req_mode, req_value, req_position));
         end
      end
      fail_count <= mismatches;
      pending    <= replies_due.size();
   end

endmodule

>>> dv/ordered_list_insert_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list insert/search core: testbench top
// Drives requests into the list core: a directed opening covering empty-list
// handling, bad positions, value extremes and the tail move on insert after
// the last node, then random requests in phases with and without idle gaps.
// A checker beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module ordered_list_insert_search_core_tb;
   import olis_pkg::*;

   localparam int CycleLimit = 500000;
   localparam int PhaseItems = 225;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   start        = 1'b0;
   logic                   busy;
   logic [1:0]             req_mode     = MODE_HEAD;
   logic signed [ValW-1:0] req_value    = '0;
   logic signed [PosW-1:0] req_position = '0;
   logic                   rsp_valid;
   logic [StatW-1:0]       rsp_status;
   logic [FidxW-1:0]       rsp_found_index;
   logic [NcntW-1:0]       rsp_node_count;
   logic signed [SumW-1:0] rsp_total_sum;
   int                     fail_count;
   int                     pending;

   // Stimulus bookkeeping: percentage of idle cycles, expected list length
   // and the values inserted so far, used as search keys.
   int                     idle_pct = 0;
   int unsigned            list_len = 0;
   logic signed [ValW-1:0] stored_keys[$];
   int                     cycle_count = 0;
   int                     phase_idle[4] = '{0, 60, 0, 29};

   ordered_list_insert_search_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_node_count  (rsp_node_count),
      .rsp_total_sum   (rsp_total_sum)
   );

   olis_checker list_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_node_count  (rsp_node_count),
      .rsp_total_sum   (rsp_total_sum),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // Free-running clock.
   initial begin
      forever #6 clock = ~clock;
   end

   // Guard against a hung core.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Issue one request, with random idle cycles ahead of it, and wait until
   // the core takes it. The list length is tracked to steer later requests.
   task automatic send_request(input logic [1:0] mode,
                               input logic signed [ValW-1:0] value,
                               input logic signed [PosW-1:0] position);
      int unsigned target;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (busy);
      target = (position <= 0) ? 0 : int'(position) - 1;
      if (list_len < Capacity &&
          (mode == MODE_HEAD || mode == MODE_TAIL ||
           (mode == MODE_AFTER && position >= 0 && list_len > 0 && target < list_len))) begin
         list_len++;
         stored_keys.push_back(value);
      end
   endtask

   // One random request, mostly well formed: positions near the list length
   // and search keys taken from stored values.
   task automatic random_request();
      int unsigned            pick;
      logic signed [ValW-1:0] value;
      logic signed [PosW-1:0] position;
      pick = $urandom_range(99);
      case ($urandom_range(19))
         0:       value = 32'sh7fffffff;
         1:       value = 32'sh80000000;
         2:       value = '0;
         3:       value = -32'sd1;
         default: value = $urandom;
      endcase
      if ($urandom_range(99) < 85) begin
         position = PosW'($urandom_range(list_len + 1));
      end else begin
         position = PosW'($urandom_range(255));
      end
      if (pick < 35) begin
         send_request($urandom_range(1) ? MODE_HEAD : MODE_TAIL, value, position);
      end else if (pick < 65) begin
         send_request(MODE_AFTER, value, position);
      end else begin
         if (stored_keys.size() > 0 && $urandom_range(99) < 70) begin
            value = stored_keys[$urandom_range(stored_keys.size() - 1)];
         end
         send_request(MODE_SEARCH, value, position);
      end
   endtask

   // Main stimulus sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list: search misses, insert after reports empty or bad position.
      send_request(MODE_SEARCH, 32'sd5, 8'sd0);
      send_request(MODE_AFTER, 32'sd9, 8'sd0);
      send_request(MODE_AFTER, 32'sd9, -8'sd1);
      send_request(MODE_AFTER, 32'sd9, 8'sh80);
      // Value extremes at head and tail.
      send_request(MODE_HEAD, 32'sh7fffffff, 8'sd0);
      send_request(MODE_TAIL, 32'sh80000000, 8'sd0);
      send_request(MODE_HEAD, -32'sd1, 8'sd0);
      // Positions zero and one both link after the head node.
      send_request(MODE_AFTER, 32'sd0, 8'sd0);
      send_request(MODE_AFTER, 32'sd123, 8'sd1);
      // Insert after the last node, then a tail insert that must follow it.
      send_request(MODE_AFTER, 32'sd55, 8'sd5);
      send_request(MODE_TAIL, 32'sd77, 8'sd0);
      // Targets beyond the end, then exactly at the end.
      send_request(MODE_AFTER, 32'sd1, 8'sd127);
      send_request(MODE_AFTER, 32'sd1, 8'sd8);
      send_request(MODE_AFTER, -32'sd5, 8'sd7);
      // Searches for the extremes, an interior node, the last node, a miss and a duplicate.
      send_request(MODE_SEARCH, 32'sh7fffffff, 8'sd0);
      send_request(MODE_SEARCH, 32'sh80000000, 8'sd0);
      send_request(MODE_SEARCH, 32'sd77, 8'sd0);
      send_request(MODE_SEARCH, -32'sd5, 8'sd0);
      send_request(MODE_SEARCH, 32'sh12345678, -8'sd1);
      send_request(MODE_SEARCH, 32'sd0, 8'sd0);
      send_request(MODE_HEAD, 32'sd0, 8'sd0);
      send_request(MODE_SEARCH, 32'sd0, 8'sd0);

      // Random phases with different amounts of idle time.
      foreach (phase_idle[ph]) begin
         idle_pct = phase_idle[ph];
         repeat (PhaseItems) random_request();
      end
      start <= 1'b0;

      // Drain outstanding responses, then watch for stray strobes.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (Capacity + 8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
